// ----- sv/suset_pkg.sv -----
// Package: shared types, codes and constants of the sorted set update core.
package suset_pkg;

  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_UPDATE
  } state_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_INSERT,
    SHIFT_DELETE
  } shift_op_t;

  typedef struct packed {
    logic      cmp_en;
    shift_op_t op;
  } cell_ctrl_t;

  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
  } rsp_t;

endpackage

// ----- sv/suset_cell.sv -----
// One storage cell of the sorted chain: holds an entry, compares and shifts.
module suset_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  suset_pkg::cell_ctrl_t                ctrl,
  input  logic signed [suset_pkg::VALUE_W-1:0] key,
  input  logic [CNT_W-1:0]                     count,
  input  logic                                 left_lt,
  input  logic signed [suset_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [suset_pkg::VALUE_W-1:0] right_entry,
  output logic signed [suset_pkg::VALUE_W-1:0] entry,
  output logic                                 lt,
  output logic                                 eq
);
  import suset_pkg::*;

  logic occupied;

  assign occupied = CNT_W'(IDX) < count;

  // Compare flags are registered; entries behind the count never matter.
  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.cmp_en) begin
      lt <= occupied && (entry < key);
      eq <= occupied && (entry == key);
    end
  end

  // Cells below the slot hold; the rest take from a neighbour.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      SHIFT_INSERT: begin
        if (!lt) begin
          entry <= left_lt ? key : left_entry;
        end
      end
      SHIFT_DELETE: begin
        if (!lt) begin
          entry <= right_entry;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

// ----- sv/sorted_unique_set_update_core.sv -----
// Top level: sorted set of distinct signed values kept in a chain of cells.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  req     | in        | req_valid / req_ready   | cmd (insert/delete), value
//  rsp     | out       | rsp_valid / rsp_ready   | status, count after the request
//
// Each request runs through three steps: accept, compare in every cell, commit.
// The commit waits while the result register is still full and unread, so a
// stalled output holds the chain; a new request is taken while a result waits.
// Reset clears the count, the control state and the output valid; cell
// contents are left as they are, since only cells below the count are read.
// A new request is accepted only after the last one commits, since the
// compare-then-shift sequence through the cell chain must finish first.
module sorted_unique_set_update_core #(
  parameter int CAPACITY = suset_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  suset_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output suset_pkg::rsp_t   rsp
);
  import suset_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t                    state;
  state_t                    state_next;
  logic                      cmd;
  logic signed [VALUE_W-1:0] key;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [COUNT_W-1:0]        count_out;
  status_t                   status_next;
  shift_op_t                 op_sel;
  cell_ctrl_t                ctrl;
  logic                      commit;
  logic                      hit;
  logic                      full;

  logic signed [VALUE_W-1:0] entry_arr [CAPACITY];
  logic [CAPACITY-1:0]       lt_vec;
  logic [CAPACITY-1:0]       eq_vec;

  // ---------------------------------------------------------------- cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                      left_lt;
    logic signed [VALUE_W-1:0] left_entry;
    logic signed [VALUE_W-1:0] right_entry;

    if (g == 0) begin : g_first
      // No left neighbour: an insert that reaches cell 0 lands here.
      assign left_lt    = 1'b1;
      assign left_entry = key;
    end else begin : g_inner
      assign left_lt    = lt_vec[g-1];
      assign left_entry = entry_arr[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_entry = entry_arr[g];
    end else begin : g_body
      assign right_entry = entry_arr[g+1];
    end

    suset_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .key         (key),
      .count       (count),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_arr[g]),
      .lt          (lt_vec[g]),
      .eq          (eq_vec[g])
    );
  end

  // ------------------------------------------------------------- decision
  // At most one cell matches, so the OR is the hit flag.
  assign hit  = |eq_vec;
  assign full = (count == CNT_W'(CAPACITY));

  always_comb begin
    status_next = ST_NOTFOUND;
    op_sel      = SHIFT_HOLD;
    count_next  = count;
    if (cmd == CMD_INSERT) begin
      if (hit) begin
        status_next = ST_DUPLICATE;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        op_sel      = SHIFT_INSERT;
        count_next  = count + CNT_W'(1);
      end
    end else begin
      if (hit) begin
        status_next = ST_REMOVED;
        op_sel      = SHIFT_DELETE;
        count_next  = count - CNT_W'(1);
      end
    end
  end

  // Reported count is the low bits of the updated count, zero-extended if narrower.
  for (genvar b = 0; b < COUNT_W; b++) begin : g_cnt
    if (b < CNT_W) begin : g_bit
      assign count_out[b] = count_next[b];
    end else begin : g_zero
      assign count_out[b] = 1'b0;
    end
  end

  // -------------------------------------------------------- state machine
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    commit      = 1'b0;
    ctrl.cmp_en = 1'b0;
    ctrl.op     = SHIFT_HOLD;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_COMPARE: begin
        ctrl.cmp_en = 1'b1;
      end
      S_UPDATE: begin
        // Hold until the result register can take the answer.
        commit  = !rsp_valid || rsp_ready;
        ctrl.op = commit ? op_sel : SHIFT_HOLD;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Latch the request and the result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= req.cmd;
      key <= req.value;
    end
    if (commit) begin
      rsp.status <= status_next;
      rsp.count  <= count_out;
    end
  end

  // ----------------------------------------------------------- assertions
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    commit && op_sel == SHIFT_INSERT |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count by one");

  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_UPDATE)
    else $error("result raised outside the commit step");

endmodule
